// ===== src/hpg_pkg.sv =====
// shared types and constants of the load-based core hotplug governor
`timescale 1ns / 1ps

package hpg_pkg;

    localparam int LOAD_W   = 15;
    localparam int RUN_W    = 8;
    localparam int MASK_W   = 4;
    localparam int KIND_W   = 3;
    localparam int ACTION_W = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    // average load is this many times the mean run count
    localparam int LOAD_SCALE = 100;
    localparam logic [LOAD_W-1:0] LOAD_MAX = 15'd25500;

    // input kinds
    localparam logic [KIND_W-1:0] KIND_SAMPLE  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_UNPAUSE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DISABLE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BOOST   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SUSPEND = 3'd4;
    localparam logic [KIND_W-1:0] KIND_RESUME  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_OFF_DONE = 3'd6;

    // actions
    localparam logic [ACTION_W-1:0] ACT_NONE        = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_ONLINE_ALL  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_ONLINE_ONE  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_OFFLINE_ONE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_OFFLINE_ALL = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CORE1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CORE2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CORE3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALL_ON = 3'd4;

    // register reset values
    localparam logic [LOAD_W-1:0] RST_CORE1_THR  = 15'd290;
    localparam logic [LOAD_W-1:0] RST_CORE2_THR  = 15'd340;
    localparam logic [LOAD_W-1:0] RST_CORE3_THR  = 15'd390;
    localparam logic [LOAD_W-1:0] RST_ALL_ON_THR = 15'd440;

    typedef struct packed {
        logic paused;
        logic disabled;
        logic boost;
        logic suspend;
        logic offline_pending;
    } t_flags;

    localparam t_flags FLAGS_RESET = '{
        paused: 1'b1, disabled: 1'b0, boost: 1'b0, suspend: 1'b0, offline_pending: 1'b0
    };

    typedef struct packed {
        logic                    enabled;
        logic [3:1][LOAD_W-1:0]  core_on;
        logic [LOAD_W-1:0]       all_on;
    } t_config;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [MASK_W-1:0] online;
        logic              flag_value;
    } t_event;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [MASK_W-1:0]   want_on;
        logic [MASK_W-1:0]   want_off;
    } t_decision;

endpackage

// ===== src/hpg_hist_ram.sv =====
// load history ring storage: one write port, one registered read port
`timescale 1ns / 1ps

module hpg_hist_ram #(
    parameter int DEPTH  = 15,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [7:0]        i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/hpg_decide.sv =====
// decision logic: per-core masks, action priority chain and flag updates
`timescale 1ns / 1ps

module hpg_decide #(
    parameter int NUM_CORES = 4
) (
    input  hpg_pkg::t_config             i_cfg,
    input  hpg_pkg::t_event              i_event,
    input  logic [hpg_pkg::LOAD_W-1:0]   i_avg,
    input  hpg_pkg::t_flags              i_flags,
    output hpg_pkg::t_decision           o_dec,
    output hpg_pkg::t_flags              o_flags
);
    import hpg_pkg::*;

    localparam int CNT_W = $clog2(NUM_CORES + 1);

    logic [CNT_W-1:0]  n_online;
    logic [MASK_W-1:0] on_mask;
    logic [MASK_W-1:0] off_mask;
    logic              all_on_hit;

    always_comb begin
        n_online = '0;
        for (int c = 0; c < NUM_CORES; c++) begin
            n_online = n_online + CNT_W'(i_event.online[c]);
        end
    end

    always_comb begin
        on_mask  = '0;
        off_mask = '0;
        for (int c = 1; c < NUM_CORES; c++) begin
            if (i_avg >= i_cfg.core_on[c] && !i_event.online[c]) begin
                on_mask[c] = 1'b1;
            end
            if (i_avg < i_cfg.core_on[c] && i_event.online[c]) begin
                off_mask[c] = 1'b1;
            end
        end
    end

    assign all_on_hit = (i_avg >= i_cfg.all_on) && (n_online < CNT_W'(NUM_CORES));

    always_comb begin
        o_dec   = '{action: ACT_NONE, want_on: '0, want_off: '0};
        o_flags = i_flags;
        if (i_cfg.enabled) begin
            case (i_event.kind)
                KIND_SAMPLE: begin
                    if (!i_flags.disabled && !i_flags.suspend) begin
                        o_dec.want_on  = on_mask;
                        o_dec.want_off = off_mask;
                        if (all_on_hit) begin
                            o_flags.paused          = 1'b1;
                            o_flags.offline_pending = 1'b0;
                            o_dec.action            = ACT_ONLINE_ALL;
                        end else if (i_flags.paused) begin
                            o_dec.action = ACT_NONE;
                        end else if (on_mask != '0) begin
                            o_flags.offline_pending = 1'b0;
                            o_dec.action            = ACT_ONLINE_ONE;
                        end else if (off_mask != '0) begin
                            if (!i_flags.offline_pending) begin
                                o_flags.offline_pending = 1'b1;
                                o_dec.action            = ACT_OFFLINE_ONE;
                            end
                            o_flags.boost = 1'b0;
                        end
                    end
                end
                KIND_UNPAUSE: begin
                    o_flags.paused = 1'b0;
                end
                KIND_DISABLE: begin
                    if (i_flags.disabled && !i_event.flag_value) begin
                        o_flags.disabled = 1'b0;
                        o_flags.paused   = 1'b0;
                    end else if (i_event.flag_value && !i_flags.disabled) begin
                        o_flags.disabled        = 1'b1;
                        o_flags.offline_pending = 1'b0;
                    end
                end
                KIND_BOOST: begin
                    if (!i_flags.suspend && !i_flags.disabled && !i_flags.boost) begin
                        o_flags.boost = 1'b1;
                        if (n_online < CNT_W'(2)) begin
                            o_flags.offline_pending = 1'b0;
                            o_flags.paused          = 1'b1;
                            o_dec.action            = ACT_ONLINE_ONE;
                        end else if (i_flags.offline_pending) begin
                            o_flags.offline_pending = 1'b0;
                            o_flags.paused          = 1'b1;
                        end
                    end
                end
                KIND_SUSPEND: begin
                    o_flags.suspend         = 1'b1;
                    o_flags.offline_pending = 1'b0;
                    if (n_online > CNT_W'(1)) begin
                        o_dec.action = ACT_OFFLINE_ALL;
                    end
                end
                KIND_RESUME: begin
                    o_flags.suspend = 1'b0;
                end
                KIND_OFF_DONE: begin
                    o_flags.offline_pending = 1'b0;
                end
                default: begin
                    o_flags = i_flags;
                end
            endcase
        end
    end

endmodule

// ===== src/load_based_core_hotplug_governor.sv =====
// top level of the load-based core hotplug governor
//
//  channel   direction  handshake                 payload
//  in        sink       i_in_valid / o_in_stall   i_kind, i_run_count, i_online_mask,
//                                                 i_flag_value
//  out       source     o_out_valid / i_out_stall o_action, o_want_on_mask,
//                                                 o_want_off_mask, o_average_load
//  cfg       sink       i_cfg_wr_en               i_cfg_index, i_cfg_data
//
// one beat per cycle while the output is not stalled; a result passes the history ram read
// stage and then the update and decision stage into the output register.
// the history ring advances only on samples, so the next read address is known at accept.
// reset is synchronous; history entries read as zero until the write pointer first wraps,
// so there is no clearing pass and beats are taken right after reset.
// an output stall holds the result register; one more beat can still enter the read stage.
`timescale 1ns / 1ps

module load_based_core_hotplug_governor #(
    parameter int NUM_CORES  = 4,
    parameter int HIST_DEPTH = 15
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [hpg_pkg::KIND_W-1:0]    i_kind,
    input  logic [hpg_pkg::RUN_W-1:0]     i_run_count,
    input  logic [hpg_pkg::MASK_W-1:0]    i_online_mask,
    input  logic                          i_flag_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [hpg_pkg::ACTION_W-1:0]  o_action,
    output logic [hpg_pkg::MASK_W-1:0]    o_want_on_mask,
    output logic [hpg_pkg::MASK_W-1:0]    o_want_off_mask,
    output logic [hpg_pkg::LOAD_W-1:0]    o_average_load,
    input  logic                          i_cfg_wr_en,
    input  logic [hpg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [hpg_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import hpg_pkg::*;

    localparam int WP_W    = $clog2(HIST_DEPTH);
    localparam int SUM_W   = $clog2(255 * HIST_DEPTH + 1);
    localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(255 * HIST_DEPTH);
    // average = (sum * 100) / depth as one multiply by a rounded-up reciprocal
    localparam int SHIFT   = SUM_W + $clog2(HIST_DEPTH);
    localparam longint unsigned MULT =
        ((longint'(LOAD_SCALE) << SHIFT) + HIST_DEPTH - 1) / HIST_DEPTH;
    localparam int PROD_W  = SHIFT + LOAD_W;

    // configuration
    t_config r_cfg;

    // read stage
    logic   r_s1_valid;
    t_event r_s1_event;
    logic [RUN_W-1:0] r_s1_run;

    // governor state
    logic [WP_W-1:0]  r_wp;
    logic [WP_W-1:0]  wp_inc;
    logic [WP_W-1:0]  n_wp;
    logic             r_wrapped;
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] n_sum;
    t_flags           r_flags;
    t_flags           n_flags;

    // output register
    logic                r_out_valid;
    t_decision           r_out_dec;
    logic [LOAD_W-1:0]   r_out_avg;

    logic              advance;
    logic              fire;
    logic              accept;
    logic              hist_upd;
    logic [7:0]        rd_data;
    logic [7:0]        hist_old;
    logic [PROD_W-1:0] prod;
    logic [LOAD_W-1:0] avg_calc;
    t_decision         dec;

    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_s1_valid && advance;
    assign o_in_stall = r_s1_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    // history moves only on samples while the governor is enabled
    assign hist_upd = fire && r_cfg.enabled && (r_s1_event.kind == KIND_SAMPLE);
    assign wp_inc   = (r_wp == WP_W'(HIST_DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign n_wp     = hist_upd ? wp_inc : r_wp;

    // entries not yet written since reset count as zero
    assign hist_old = r_wrapped ? rd_data : 8'd0;

    assign n_sum = hist_upd ? SUM_W'(r_sum - SUM_W'(hist_old) + SUM_W'(r_s1_run)) : r_sum;
    assign prod     = PROD_W'(n_sum) * PROD_W'(MULT);
    assign avg_calc = prod[PROD_W-1:SHIFT];

    hpg_hist_ram #(
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .i_clk     (i_clk),
        .i_wr_en   (hist_upd),
        .i_wr_addr (r_wp),
        .i_wr_data (r_s1_run),
        .i_rd_en   (accept),
        .i_rd_addr (n_wp),
        .o_rd_data (rd_data)
    );

    hpg_decide #(
        .NUM_CORES (NUM_CORES)
    ) u_decide (
        .i_cfg   (r_cfg),
        .i_event (r_s1_event),
        .i_avg   (avg_calc),
        .i_flags (r_flags),
        .o_dec   (dec),
        .o_flags (n_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enabled    <= 1'b1;
            r_cfg.core_on[1] <= RST_CORE1_THR;
            r_cfg.core_on[2] <= RST_CORE2_THR;
            r_cfg.core_on[3] <= RST_CORE3_THR;
            r_cfg.all_on     <= RST_ALL_ON_THR;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_ENABLE: r_cfg.enabled    <= i_cfg_data[0];
                CFG_CORE1:  r_cfg.core_on[1] <= i_cfg_data[LOAD_W-1:0];
                CFG_CORE2:  r_cfg.core_on[2] <= i_cfg_data[LOAD_W-1:0];
                CFG_CORE3:  r_cfg.core_on[3] <= i_cfg_data[LOAD_W-1:0];
                CFG_ALL_ON: r_cfg.all_on     <= i_cfg_data[LOAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_event.kind       <= i_kind;
            r_s1_event.online     <= i_online_mask;
            r_s1_event.flag_value <= i_flag_value;
            r_s1_run              <= i_run_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_wrapped <= 1'b0;
            r_sum     <= '0;
            r_flags   <= FLAGS_RESET;
        end else if (fire) begin
            r_wp    <= n_wp;
            r_sum   <= n_sum;
            r_flags <= n_flags;
            if (hist_upd && r_wp == WP_W'(HIST_DEPTH - 1)) begin
                r_wrapped <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_dec <= dec;
            r_out_avg <= r_cfg.enabled ? avg_calc : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_action        = r_out_dec.action;
    assign o_want_on_mask  = r_out_dec.want_on;
    assign o_want_off_mask = r_out_dec.want_off;
    assign o_average_load  = r_out_avg;

`ifndef SYNTHESIS
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid))
        else $error("input stalled with read stage empty");

    a_wp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp <= WP_W'(HIST_DEPTH - 1))
        else $error("history write pointer out of range");

    a_sum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sum <= SUM_MAX)
        else $error("history sum above window maximum");

    a_avg_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_average_load <= LOAD_MAX))
        else $error("average load above limit");
`endif

endmodule

// ===== tb/sv/hotplug_checker.sv =====
// predicts and checks the hotplug governor's decisions from the channels it watches
`timescale 1ns / 1ps

module hotplug_checker #(
    parameter int NUM_CORES  = 4,
    parameter int HIST_DEPTH = 15
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [hpg_pkg::KIND_W-1:0]     i_kind,
    input  logic [hpg_pkg::RUN_W-1:0]      i_run_count,
    input  logic [hpg_pkg::MASK_W-1:0]     i_online_mask,
    input  logic                           i_flag_value,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [hpg_pkg::ACTION_W-1:0]   i_action,
    input  logic [hpg_pkg::MASK_W-1:0]     i_want_on_mask,
    input  logic [hpg_pkg::MASK_W-1:0]     i_want_off_mask,
    input  logic [hpg_pkg::LOAD_W-1:0]     i_average_load,
    input  logic                           i_cfg_wr_en,
    input  logic [hpg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hpg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked
);
    import hpg_pkg::*;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [MASK_W-1:0]   want_on;
        logic [MASK_W-1:0]   want_off;
        logic [LOAD_W-1:0]   load;
    } t_outcome;

    t_outcome         expected_outcomes [$];
    logic [RUN_W-1:0] run_ring [HIST_DEPTH];
    int unsigned      ring_pos;
    int unsigned      ring_sum;
    t_flags           flags;
    t_config          cfg;

    function automatic t_outcome decide(input logic [KIND_W-1:0] kind,
                                        input logic [RUN_W-1:0]  run,
                                        input logic [MASK_W-1:0] online,
                                        input logic              flag);
        t_outcome    r;
        int unsigned n_on;
        int unsigned avg;
        logic        met;
        r = '0;
        if (!cfg.enabled) begin
            return r;
        end
        n_on = 0;
        for (int c = 0; c < NUM_CORES; c++) begin
            n_on += online[c];
        end
        case (kind)
            KIND_SAMPLE: begin
                ring_sum = ring_sum - run_ring[ring_pos] + run;
                run_ring[ring_pos] = run;
                ring_pos = (ring_pos + 1 >= HIST_DEPTH) ? 0 : ring_pos + 1;
                avg = ring_sum * LOAD_SCALE / HIST_DEPTH;
                if (!flags.disabled && !flags.suspend) begin
                    for (int c = 1; c < NUM_CORES; c++) begin
                        met = (avg >= cfg.core_on[c]);
                        if (met && !online[c]) begin
                            r.want_on[c] = 1'b1;
                        end else if (!met && online[c]) begin
                            r.want_off[c] = 1'b1;
                        end
                    end
                    if (avg >= cfg.all_on && n_on < NUM_CORES) begin
                        flags.paused          = 1'b1;
                        flags.offline_pending = 1'b0;
                        r.action              = ACT_ONLINE_ALL;
                    end else if (flags.paused) begin
                        r.action = ACT_NONE;
                    end else if (r.want_on != '0) begin
                        flags.offline_pending = 1'b0;
                        r.action              = ACT_ONLINE_ONE;
                    end else if (r.want_off != '0) begin
                        // only one offline request in flight at a time
                        if (!flags.offline_pending) begin
                            flags.offline_pending = 1'b1;
                            r.action              = ACT_OFFLINE_ONE;
                        end
                        flags.boost = 1'b0;
                    end
                end
            end
            KIND_UNPAUSE: begin
                flags.paused = 1'b0;
            end
            KIND_DISABLE: begin
                if (flags.disabled && !flag) begin
                    flags.disabled = 1'b0;
                    flags.paused   = 1'b0;
                end else if (flag && !flags.disabled) begin
                    flags.disabled        = 1'b1;
                    flags.offline_pending = 1'b0;
                end
            end
            KIND_BOOST: begin
                if (!flags.suspend && !flags.disabled && !flags.boost) begin
                    flags.boost = 1'b1;
                    if (n_on < 2) begin
                        flags.offline_pending = 1'b0;
                        flags.paused          = 1'b1;
                        r.action              = ACT_ONLINE_ONE;
                    end else if (flags.offline_pending) begin
                        flags.offline_pending = 1'b0;
                        flags.paused          = 1'b1;
                    end
                end
            end
            KIND_SUSPEND: begin
                flags.suspend         = 1'b1;
                flags.offline_pending = 1'b0;
                if (n_on > 1) begin
                    r.action = ACT_OFFLINE_ALL;
                end
            end
            KIND_RESUME: begin
                flags.suspend = 1'b0;
            end
            KIND_OFF_DONE: begin
                flags.offline_pending = 1'b0;
            end
            default: ;
        endcase
        r.load = LOAD_W'(ring_sum * LOAD_SCALE / HIST_DEPTH);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            foreach (run_ring[i]) begin
                run_ring[i] = '0;
            end
            ring_pos           = 0;
            ring_sum           = 0;
            flags              = FLAGS_RESET;
            cfg.enabled        = 1'b1;
            cfg.core_on[1]     = RST_CORE1_THR;
            cfg.core_on[2]     = RST_CORE2_THR;
            cfg.core_on[3]     = RST_CORE3_THR;
            cfg.all_on         = RST_ALL_ON_THR;
            expected_outcomes.delete();
            o_fail_count       = 0;
            o_checked          = 0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_ENABLE: cfg.enabled    = i_cfg_data[0];
                    CFG_CORE1:  cfg.core_on[1] = i_cfg_data;
                    CFG_CORE2:  cfg.core_on[2] = i_cfg_data;
                    CFG_CORE3:  cfg.core_on[3] = i_cfg_data;
                    CFG_ALL_ON: cfg.all_on     = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_outcomes.size() == 0) begin
                    $error("result beat with no decision waiting");
                    o_fail_count++;
                end else begin
                    want = expected_outcomes.pop_front();
                    o_checked++;
                    if (i_action !== want.action) begin
                        $error("action: expected %0d, got %0d", want.action, i_action);
                        o_fail_count++;
                    end
                    if (i_want_on_mask !== want.want_on) begin
                        $error("want_on_mask: expected %b, got %b",
                               want.want_on, i_want_on_mask);
                        o_fail_count++;
                    end
                    if (i_want_off_mask !== want.want_off) begin
                        $error("want_off_mask: expected %b, got %b",
                               want.want_off, i_want_off_mask);
                        o_fail_count++;
                    end
                    if (i_average_load !== want.load) begin
                        $error("average_load: expected %0d, got %0d",
                               want.load, i_average_load);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_outcomes.push_back(
                    decide(i_kind, i_run_count, i_online_mask, i_flag_value));
            end
        end
        o_pending = expected_outcomes.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
// testbench top: drives events and thresholds into the hotplug governor and gives the verdict
`timescale 1ns / 1ps

module tb;
    import hpg_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 100000;
    localparam int PHASES      = 8;
    localparam int PHASE_BEATS = 142;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [KIND_W-1:0]     i_kind;
    logic [RUN_W-1:0]      i_run_count;
    logic [MASK_W-1:0]     i_online_mask;
    logic                  i_flag_value;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [ACTION_W-1:0]   o_action;
    logic [MASK_W-1:0]     o_want_on_mask;
    logic [MASK_W-1:0]     o_want_off_mask;
    logic [LOAD_W-1:0]     o_average_load;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int fail_count;
    int pending;
    int checked;
    int cycle_count   = 0;
    int beats_sent    = 0;
    int samples_sent  = 0;
    int send_gap_pct  = 0;
    int out_stall_pct = 0;
    int run_ceiling   = 8;

    load_based_core_hotplug_governor DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_run_count     (i_run_count),
        .i_online_mask   (i_online_mask),
        .i_flag_value    (i_flag_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_action        (o_action),
        .o_want_on_mask  (o_want_on_mask),
        .o_want_off_mask (o_want_off_mask),
        .o_average_load  (o_average_load),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    hotplug_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_run_count     (i_run_count),
        .i_online_mask   (i_online_mask),
        .i_flag_value    (i_flag_value),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_action        (o_action),
        .i_want_on_mask  (o_want_on_mask),
        .i_want_off_mask (o_want_off_mask),
        .i_average_load  (o_average_load),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // entered and left at a falling edge; valid stays high across back-to-back beats
    task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [RUN_W-1:0] run,
                             input logic [MASK_W-1:0] online, input logic flag);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_kind        = kind;
        i_run_count   = run;
        i_online_mask = online;
        i_flag_value  = flag;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        beats_sent++;
        if (kind == KIND_SAMPLE) begin
            samples_sent++;
        end
    endtask

    task automatic send_random_beat();
        logic [KIND_W-1:0] kind;
        logic [RUN_W-1:0]  run;
        logic              flag;
        int                pick;
        pick = $urandom_range(99);
        if (pick < 58)      kind = KIND_SAMPLE;
        else if (pick < 66) kind = KIND_UNPAUSE;
        else if (pick < 71) kind = KIND_DISABLE;
        else if (pick < 77) kind = KIND_BOOST;
        else if (pick < 81) kind = KIND_SUSPEND;
        else if (pick < 90) kind = KIND_RESUME;
        else if (pick < 98) kind = KIND_OFF_DONE;
        else                kind = KIND_UNUSED;
        // light loads keep the window average near the thresholds, with rare bursts
        if ($urandom_range(39) == 0) begin
            run = RUN_W'($urandom);
        end else begin
            run = RUN_W'($urandom_range(run_ceiling));
        end
        if (kind == KIND_DISABLE) begin
            flag = ($urandom_range(99) < 35);
        end else begin
            flag = 1'($urandom_range(1));
        end
        send_beat(kind, run, MASK_W'($urandom), flag);
    endtask

    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_kind        = KIND_SAMPLE;
        i_run_count   = '0;
        i_online_mask = '0;
        i_flag_value  = 1'b0;
        i_out_stall   = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = CFG_ENABLE;
        i_cfg_data    = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // boot pause, full-scale samples, online-all, boost, suspend, disable toggles
        send_beat(KIND_SAMPLE,   8'd0,   4'b0000, 1'b0);
        send_beat(KIND_SAMPLE,   8'd255, 4'b1111, 1'b1);
        send_beat(KIND_SAMPLE,   8'd255, 4'b0001, 1'b0);
        send_beat(KIND_UNPAUSE,  8'd0,   4'b0000, 1'b0);
        send_beat(KIND_SAMPLE,   8'd255, 4'b1111, 1'b0);
        send_beat(KIND_BOOST,    8'd0,   4'b0001, 1'b0);
        send_beat(KIND_BOOST,    8'd0,   4'b0011, 1'b0);
        send_beat(KIND_UNPAUSE,  8'd0,   4'b0000, 1'b0);
        send_beat(KIND_SUSPEND,  8'd0,   4'b1111, 1'b0);
        send_beat(KIND_SAMPLE,   8'd255, 4'b0000, 1'b0);
        send_beat(KIND_SUSPEND,  8'd0,   4'b0001, 1'b0);
        send_beat(KIND_RESUME,   8'd0,   4'b0000, 1'b0);
        send_beat(KIND_DISABLE,  8'd0,   4'b0000, 1'b1);
        send_beat(KIND_SAMPLE,   8'd128, 4'b0101, 1'b0);
        send_beat(KIND_BOOST,    8'd0,   4'b0000, 1'b0);
        send_beat(KIND_DISABLE,  8'd0,   4'b0000, 1'b1);
        send_beat(KIND_DISABLE,  8'd0,   4'b0000, 1'b0);
        send_beat(KIND_DISABLE,  8'd0,   4'b0000, 1'b0);
        send_beat(KIND_OFF_DONE, 8'd0,   4'b1010, 1'b0);
        send_beat(KIND_UNUSED,   8'd255, 4'b1111, 1'b1);
        send_beat(KIND_SAMPLE,   8'd1,   4'b1110, 1'b0);

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            if (phase == 2) begin
                write_reg(CFG_CORE1, '0);
                write_reg(CFG_CORE2, '0);
                write_reg(CFG_CORE3, '0);
                write_reg(CFG_ALL_ON, '0);
            end else if (phase == 5) begin
                write_reg(CFG_CORE1, LOAD_MAX);
                write_reg(CFG_CORE2, LOAD_MAX);
                write_reg(CFG_CORE3, LOAD_MAX);
                write_reg(CFG_ALL_ON, LOAD_MAX);
            end else if (phase != 0) begin
                write_reg(CFG_CORE1, CFG_DATA_W'($urandom_range(600)));
                write_reg(CFG_CORE2, CFG_DATA_W'($urandom_range(700)));
                write_reg(CFG_CORE3, CFG_DATA_W'($urandom_range(800)));
                write_reg(CFG_ALL_ON, CFG_DATA_W'($urandom_range(1200, 200)));
            end
            run_ceiling = $urandom_range(12, 3);
            case (phase % 4)
                0: begin send_gap_pct = 0;  out_stall_pct = 0;  end
                1: begin send_gap_pct = 50; out_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  out_stall_pct = 50; end
                default: begin send_gap_pct = 25; out_stall_pct = 25; end
            endcase
            for (int n = 0; n < PHASE_BEATS; n++) begin
                if (n == PHASE_BEATS / 2 && phase % 3 == 1) begin
                    wait_drained();
                end
                send_random_beat();
            end
            if (phase == 3) begin
                // governor switched off: every beat should come back all zero
                wait_drained();
                write_reg(CFG_ENABLE, 15'd0);
                for (int n = 0; n < 30; n++) begin
                    send_random_beat();
                end
                wait_drained();
                write_reg(CFG_ENABLE, 15'd1);
            end
        end

        wait_drained();
        out_stall_pct = 0;
        $display("covered %0d event beats (%0d samples) over %0d threshold settings,",
                 beats_sent, samples_sent, PHASES);
        $display("a disabled stretch and four idle patterns; %0d decisions compared", checked);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
